// ===== rtl/sync_length_sum_deframer_defines.svh =====
// Assertion macros for the deframer checker file.
`ifndef SYNC_LENGTH_SUM_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_SUM_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SLFD_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define SLFD_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

// ===== rtl/slfd_pkg.sv =====
// Shared types and constants of the sync/length/sum deframer.
package slfd_pkg;

   localparam int FRAME_BYTES_DEF = 32;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [7:0] SYNC_FIRST     = 8'h5A;
   localparam logic [7:0] SYNC_SECOND    = 8'hA5;
   localparam logic [4:0] MIN_LEN_RESET  = 5'd3;
   localparam logic [9:0] FRAME_OVERHEAD = 10'd5;
   localparam logic [2:0] OFF_FULL       = 3'd4;
   localparam logic [2:0] OFF_BROKEN     = 3'd7;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_SUM   = 3'd1,
      ST_SHORT = 3'd2,
      ST_OFF   = 3'd3,
      ST_LONG  = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   kind;
      status_type status;
      logic       last;
   } result_type;

   // ECU-off pattern 4A 00 00 4E
   function automatic logic [7:0] off_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h4A;
         2'd3:    b = 8'h4E;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/slfd_front.sv =====
// Front end: sync hunt, length and checksum tracking, result classification.
module slfd_front #(
   parameter int FRAME_BYTES = slfd_pkg::FRAME_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           rx_byte,
   input  logic                 restart,
   input  logic                 cfg_we,
   input  logic [4:0]           cfg_data,
   output logic                 push,
   output slfd_pkg::result_type result
);

   localparam int         CNT_W       = $clog2(FRAME_BYTES);
   localparam logic [9:0] FRAME_LIMIT = 10'(FRAME_BYTES);

   typedef enum logic [6:0] {
      PH_SYNC1 = 7'b0000001,
      PH_SYNC2 = 7'b0000010,
      PH_DLEN  = 7'b0000100,
      PH_DATA  = 7'b0001000,
      PH_HLEN  = 7'b0010000,
      PH_HDR   = 7'b0100000,
      PH_SUM   = 7'b1000000
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] dlen_ff, dlen_in;
   logic [CNT_W-1:0] hlen_ff, hlen_in;
   logic [7:0]       sum_ff, sum_in;
   logic [2:0]       off_ff, off_in;
   logic [4:0]       min_len_ff;

   logic [2:0]       off_next;
   logic             off_hit;
   logic [7:0]       sum_add;
   logic [CNT_W-1:0] count_inc;
   logic [9:0]       dlen_total;
   logic [9:0]       frame_total;

   always_comb begin
      off_next = off_ff;
      if (off_ff < slfd_pkg::OFF_FULL) begin
         off_next = (rx_byte == slfd_pkg::off_byte(off_ff[1:0])) ? off_ff + 3'd1
                                                                 : slfd_pkg::OFF_BROKEN;
      end
      off_hit     = (off_next == slfd_pkg::OFF_FULL);
      sum_add     = sum_ff + rx_byte;
      count_inc   = count_ff + CNT_W'(1);
      dlen_total  = {2'b00, rx_byte} + slfd_pkg::FRAME_OVERHEAD;
      frame_total = 10'(dlen_ff) + {2'b00, rx_byte} + slfd_pkg::FRAME_OVERHEAD;
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      dlen_in  = dlen_ff;
      hlen_in  = hlen_ff;
      sum_in   = sum_ff;
      off_in   = off_ff;
      push     = 1'b0;
      result   = '{out_byte: rx_byte, kind: slfd_pkg::KIND_DATA,
                   status: slfd_pkg::ST_OK, last: 1'b0};
      if (take) begin
         if (restart) begin
            phase_in = PH_SYNC1;
         end else begin
            unique case (phase_ff)
               PH_SYNC2: begin
                  if (rx_byte == slfd_pkg::SYNC_SECOND) begin
                     phase_in = PH_DLEN;
                  end else if (rx_byte != slfd_pkg::SYNC_FIRST) begin
                     phase_in = PH_SYNC1;
                  end
               end
               PH_DLEN: begin
                  dlen_in  = rx_byte[CNT_W-1:0];
                  sum_in   = rx_byte;
                  count_in = '0;
                  off_in   = '0;
                  if ({3'b000, min_len_ff} > rx_byte) begin
                     push     = 1'b1;
                     result   = '{8'h00, slfd_pkg::KIND_STATUS, slfd_pkg::ST_SHORT, 1'b1};
                     phase_in = PH_SYNC1;
                  end else if (dlen_total > FRAME_LIMIT) begin
                     push     = 1'b1;
                     result   = '{8'h00, slfd_pkg::KIND_STATUS, slfd_pkg::ST_LONG, 1'b1};
                     phase_in = PH_SYNC1;
                  end else begin
                     phase_in = (rx_byte == 8'h00) ? PH_HLEN : PH_DATA;
                  end
               end
               PH_DATA: begin
                  sum_in = sum_add;
                  off_in = off_next;
                  push   = 1'b1;
                  if (off_hit) begin
                     result   = '{8'h00, slfd_pkg::KIND_STATUS, slfd_pkg::ST_OFF, 1'b1};
                     phase_in = PH_SYNC1;
                  end else if (count_inc >= dlen_ff) begin
                     count_in = '0;
                     phase_in = PH_HLEN;
                  end else begin
                     count_in = count_inc;
                  end
               end
               PH_HLEN: begin
                  sum_in  = sum_add;
                  off_in  = off_next;
                  hlen_in = rx_byte[CNT_W-1:0];
                  if (off_hit) begin
                     push     = 1'b1;
                     result   = '{8'h00, slfd_pkg::KIND_STATUS, slfd_pkg::ST_OFF, 1'b1};
                     phase_in = PH_SYNC1;
                  end else if (frame_total > FRAME_LIMIT) begin
                     push     = 1'b1;
                     result   = '{8'h00, slfd_pkg::KIND_STATUS, slfd_pkg::ST_LONG, 1'b1};
                     phase_in = PH_SYNC1;
                  end else begin
                     count_in = '0;
                     phase_in = (rx_byte == 8'h00) ? PH_SUM : PH_HDR;
                  end
               end
               PH_HDR: begin
                  sum_in      = sum_add;
                  push        = 1'b1;
                  result.kind = slfd_pkg::KIND_HEADER;
                  if (count_inc >= hlen_ff) begin
                     count_in = '0;
                     phase_in = PH_SUM;
                  end else begin
                     count_in = count_inc;
                  end
               end
               PH_SUM: begin
                  push     = 1'b1;
                  result   = '{8'h00, slfd_pkg::KIND_STATUS,
                               (rx_byte == sum_ff) ? slfd_pkg::ST_OK : slfd_pkg::ST_SUM,
                               1'b1};
                  phase_in = PH_SYNC1;
               end
               default: begin
                  phase_in = (rx_byte == slfd_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SYNC1;
         count_ff   <= '0;
         dlen_ff    <= '0;
         hlen_ff    <= '0;
         sum_ff     <= '0;
         off_ff     <= '0;
         min_len_ff <= slfd_pkg::MIN_LEN_RESET;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         dlen_ff  <= dlen_in;
         hlen_ff  <= hlen_in;
         sum_ff   <= sum_in;
         off_ff   <= off_in;
         if (cfg_we) begin
            min_len_ff <= cfg_data;
         end
      end
   end

endmodule

// ===== rtl/slfd_queue.sv =====
// Result queue between the front end and the response port.
module slfd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  slfd_pkg::result_type push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 valid,
   output slfd_pkg::result_type head
);

   localparam int PTR_W = (slfd_pkg::QUEUE_DEPTH > 1) ? $clog2(slfd_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(slfd_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(slfd_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(slfd_pkg::QUEUE_DEPTH);

   slfd_pkg::result_type mem_ff [slfd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wptr_ff, wptr_in;
   logic [PTR_W-1:0]     rptr_ff, rptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full  = (count_ff == CNT_FULL);
   assign valid = (count_ff != '0);
   assign head  = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == PTR_LAST) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/sync_length_sum_deframer.sv =====
// Top level of the sync/length/sum deframer.
//
//   channel  direction  handshake         payload
//   req      in         valid / stall     rx_byte, restart
//   rsp      out        valid / stall     out_byte, kind, status, last
//   csr      in         valid / ready     data (min data length)
//
// One byte per cycle while req is not stalled: the front end classifies each word
// in the cycle it is taken, and the two-entry result queue sets the stall seen on req.
// A result is written into the result queue and reaches rsp once it is at the queue head.
// Reset clears the phase, counters and queue; min data length returns to 3.
// req stalls only while the queue is full; csr is always ready.
module sync_length_sum_deframer #(
   parameter int FRAME_BYTES = slfd_pkg::FRAME_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_restart,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic [2:0] rsp_status,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_data
);

   logic                 take;
   logic                 push;
   logic                 full;
   slfd_pkg::result_type result;
   slfd_pkg::result_type head;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign take      = req_valid && !full;

   slfd_front #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req_rx_byte),
      .restart (req_restart),
      .cfg_we  (csr_valid && csr_ready),
      .cfg_data(csr_data),
      .push    (push),
      .result  (result)
   );

   slfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(result),
      .pop      (rsp_valid && !rsp_stall),
      .full     (full),
      .valid    (rsp_valid),
      .head     (head)
   );

   assign rsp_out_byte = head.out_byte;
   assign rsp_kind     = head.kind;
   assign rsp_status   = head.status;
   assign rsp_last     = head.last;

endmodule

// ===== rtl/slfd_checker.sv =====
// Port-level checker for the deframer and its bind to the top level.
`include "sync_length_sum_deframer_defines.svh"

module slfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_restart,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_kind,
   input logic [2:0] rsp_status,
   input logic       rsp_last
);

   logic        req_take;
   logic        is_status;
   logic        payload_ok;
   logic [13:0] rsp_word;

   assign req_take   = req_valid && !req_stall;
   assign is_status  = (rsp_kind == slfd_pkg::KIND_STATUS);
   assign payload_ok = !rsp_last && rsp_status == slfd_pkg::ST_OK &&
                       (rsp_kind == slfd_pkg::KIND_DATA || rsp_kind == slfd_pkg::KIND_HEADER);
   assign rsp_word   = {rsp_out_byte, rsp_kind, rsp_status, rsp_last};

   `SLFD_ASSERT_IMPL(a_status_shape, rsp_valid && is_status, rsp_last && rsp_out_byte == 8'h00)
   `SLFD_ASSERT_IMPL(a_payload_shape, rsp_valid && !is_status, payload_ok)
   `SLFD_ASSERT_NEXT(a_no_invented, !rsp_valid && !req_take, !rsp_valid)
   `SLFD_ASSERT_NEXT(a_restart_silent, !rsp_valid && req_take && req_restart, !rsp_valid)
   `SLFD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

endmodule

bind sync_length_sum_deframer slfd_checker u_slfd_checker (.*);

// ===== tb/sv/sync_length_sum_deframer_tb.sv =====
// Self-checking testbench for the sync/length/sum deframer: directed table, then random frames.
module sync_length_sum_deframer_tb;

   localparam int FRAME_LIMIT = slfd_pkg::FRAME_BYTES_DEF;
   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 120;
   localparam logic [7:0] ECU_OFF_SEQ [4] = '{8'h4A, 8'h00, 8'h00, 8'h4E};

   typedef enum logic [2:0] {
      HUNT_FIRST, HUNT_SECOND, TAKE_DLEN, TAKE_DATA, TAKE_HLEN, TAKE_HDR, TAKE_SUM
   } frame_phase_type;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE
   } stall_mode_type;

   typedef struct packed {
      logic                 [7:0] rx;
      logic                 restart;
      logic                 typed;
      slfd_pkg::status_type st;
   } directed_row_type;

   localparam directed_row_type DIRECTED [26] = '{
      '{8'h5A, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'h5A, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'hA5, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'h01, 1'b0, 1'b1, slfd_pkg::ST_SHORT},
      '{8'h5A, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'hA5, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'hFF, 1'b0, 1'b1, slfd_pkg::ST_LONG},
      '{8'h5A, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'hA5, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'h03, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'h4A, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'h00, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'h00, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'h4E, 1'b0, 1'b1, slfd_pkg::ST_OFF},
      '{8'h5A, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'hA5, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'hFF, 1'b1, 1'b0, slfd_pkg::ST_OK},
      '{8'h5A, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'hA5, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'h03, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'h11, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'h22, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'h33, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'h01, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'h44, 1'b0, 1'b0, slfd_pkg::ST_OK},
      '{8'h00, 1'b0, 1'b1, slfd_pkg::ST_SUM}
   };

   logic       clock;
   logic       reset        = 1'b1;
   logic       req_valid    = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte  = 8'h00;
   logic       req_restart  = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall    = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_kind;
   logic [2:0] rsp_status;
   logic       rsp_last;
   logic       csr_valid    = 1'b0;
   logic       csr_ready;
   logic [4:0] csr_data     = 5'd0;

   frame_phase_type frame_phase;
   logic [7:0]      taken;
   logic [7:0]      dlen;
   logic [7:0]      hlen;
   logic [7:0]      rsum;
   logic [2:0]      offm;
   logic [4:0]      min_len;

   slfd_pkg::result_type expected_words [$];
   int                   error_count = 0;
   int                   words_taken = 0;
   int                   burst_left  = 0;
   int                   idle_cycles = 0;
   bit                   hold_done   = 1'b0;

   sync_length_sum_deframer u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_byte  (req_rx_byte),
      .req_restart  (req_restart),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_kind     (rsp_kind),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void clear_frame();
      frame_phase = HUNT_FIRST;
      taken = 8'd0;
      dlen  = 8'd0;
      hlen  = 8'd0;
      rsum  = 8'd0;
      offm  = 3'd0;
   endfunction

   function automatic slfd_pkg::result_type status_word(slfd_pkg::status_type s);
      slfd_pkg::result_type w;
      w.out_byte = 8'h00;
      w.kind     = slfd_pkg::KIND_STATUS;
      w.status   = s;
      w.last     = 1'b1;
      return w;
   endfunction

   function automatic slfd_pkg::result_type frame_end(slfd_pkg::status_type s);
      clear_frame();
      return status_word(s);
   endfunction

   function automatic slfd_pkg::result_type payload_word(logic [7:0] b,
                                                         slfd_pkg::kind_type k);
      slfd_pkg::result_type w;
      w.out_byte = b;
      w.kind     = k;
      w.status   = slfd_pkg::ST_OK;
      w.last     = 1'b0;
      return w;
   endfunction

   function automatic bit off_match(logic [7:0] b);
      if (offm < slfd_pkg::OFF_FULL) begin
         if (b == ECU_OFF_SEQ[offm[1:0]]) offm = offm + 3'd1;
         else offm = slfd_pkg::OFF_BROKEN;
         return offm == slfd_pkg::OFF_FULL;
      end
      return 1'b0;
   endfunction

   task automatic deframe_predict(input logic [7:0] b, input logic r,
                                  output bit got, output slfd_pkg::result_type res);
      got = 1'b0;
      res = status_word(slfd_pkg::ST_OK);
      if (r) begin
         clear_frame();
         return;
      end
      case (frame_phase)
         HUNT_SECOND: begin
            if (b == slfd_pkg::SYNC_SECOND) frame_phase = TAKE_DLEN;
            else if (b != slfd_pkg::SYNC_FIRST) frame_phase = HUNT_FIRST;
         end
         TAKE_DLEN: begin
            dlen  = b;
            rsum  = b;
            taken = 8'd0;
            offm  = 3'd0;
            if (b < min_len) begin
               got = 1'b1;
               res = frame_end(slfd_pkg::ST_SHORT);
            end else if (int'(b) + 5 > FRAME_LIMIT) begin
               got = 1'b1;
               res = frame_end(slfd_pkg::ST_LONG);
            end else begin
               frame_phase = (b == 8'd0) ? TAKE_HLEN : TAKE_DATA;
            end
         end
         TAKE_DATA: begin
            rsum = rsum + b;
            got  = 1'b1;
            if (off_match(b)) begin
               res = frame_end(slfd_pkg::ST_OFF);
            end else begin
               taken = taken + 8'd1;
               if (taken >= dlen) begin
                  taken = 8'd0;
                  frame_phase = TAKE_HLEN;
               end
               res = payload_word(b, slfd_pkg::KIND_DATA);
            end
         end
         TAKE_HLEN: begin
            hlen = b;
            rsum = rsum + b;
            if (off_match(b)) begin
               got = 1'b1;
               res = frame_end(slfd_pkg::ST_OFF);
            end else if (int'(dlen) + int'(b) + 5 > FRAME_LIMIT) begin
               got = 1'b1;
               res = frame_end(slfd_pkg::ST_LONG);
            end else begin
               taken = 8'd0;
               frame_phase = (b == 8'd0) ? TAKE_SUM : TAKE_HDR;
            end
         end
         TAKE_HDR: begin
            rsum  = rsum + b;
            taken = taken + 8'd1;
            if (taken >= hlen) begin
               taken = 8'd0;
               frame_phase = TAKE_SUM;
            end
            got = 1'b1;
            res = payload_word(b, slfd_pkg::KIND_HEADER);
         end
         TAKE_SUM: begin
            got = 1'b1;
            res = frame_end((b == rsum) ? slfd_pkg::ST_OK : slfd_pkg::ST_SUM);
         end
         default: begin
            frame_phase = (b == slfd_pkg::SYNC_FIRST) ? HUNT_SECOND : HUNT_FIRST;
         end
      endcase
   endtask

   task automatic send_word(input logic [7:0] b, input logic r, input logic typed,
                            input slfd_pkg::status_type st);
      int                   gap;
      bit                   got;
      slfd_pkg::result_type res;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      req_restart <= r;
      do @(posedge clock); while (req_stall);
      words_taken++;
      deframe_predict(b, r, got, res);
      if (typed) expected_words.push_back(status_word(st));
      else if (got) expected_words.push_back(res);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_frame();
      int         sel;
      int         dl;
      int         hl;
      int         plen;
      int         lo;
      int         n;
      logic [7:0] seq [$];
      logic [7:0] acc;
      bit         whole;
      sel  = $urandom_range(0, 99);
      plen = 0;
      lo   = int'(min_len);
      repeat ($urandom_range(0, 2))
         send_word(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, 1'b0,
                   slfd_pkg::ST_OK);
      if ($urandom_range(0, 3) == 0)
         send_word(slfd_pkg::SYNC_FIRST, 1'b0, 1'b0, slfd_pkg::ST_OK);
      send_word(slfd_pkg::SYNC_FIRST, 1'b0, 1'b0, slfd_pkg::ST_OK);
      send_word(slfd_pkg::SYNC_SECOND, 1'b0, 1'b0, slfd_pkg::ST_OK);
      if (sel < 10) begin
         if (lo < 3) lo = 3;
         plen = $urandom_range(2, 4);
      end
      if (sel >= 10 && sel < 20 && lo > 0) dl = $urandom_range(0, lo - 1);
      else if (sel >= 20 && sel < 27) dl = $urandom_range(28, 255);
      else dl = (lo <= 27) ? $urandom_range(lo, 27) : lo;
      if (sel >= 27 && sel < 35 && dl <= 27) hl = $urandom_range(28 - dl, 255);
      else hl = (dl <= 27) ? $urandom_range(0, 27 - dl) : 0;
      whole = (dl <= 27) && (dl + hl <= 27);
      seq.push_back(8'(dl));
      if (dl <= 27) begin
         repeat (dl) seq.push_back(8'($urandom_range(0, 255)));
         seq.push_back(8'(hl));
         if (whole) repeat (hl) seq.push_back(8'($urandom_range(0, 255)));
      end
      for (int i = 1; i <= plen; i++)
         if (i < seq.size()) seq[i] = ECU_OFF_SEQ[i - 1];
      if (whole) begin
         acc = 8'd0;
         foreach (seq[i]) acc = acc + seq[i];
         seq.push_back(($urandom_range(0, 5) == 0) ? acc + 8'($urandom_range(1, 255)) : acc);
      end
      n = seq.size();
      // cut the frame short and drop it with a restart word
      if (sel >= 90) n = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++) send_word(seq[i], 1'b0, 1'b0, slfd_pkg::ST_OK);
      if (sel >= 90) send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0, slfd_pkg::ST_OK);
   endtask

   initial begin
      stall_mode_type mode;
      int             len;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         len  = $urandom_range(10, 60);
         if (!hold_done && words_taken >= 200) begin
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            repeat (len) begin
               @(posedge clock);
               case (mode)
                  STALL_NONE:  rsp_stall <= 1'b0;
                  STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                  STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default:     rsp_stall <= ~rsp_stall;
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      slfd_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            error_count++;
            $display("%0t: unexpected rsp word, expected none, actual %s %h %s %0d %s %0d %s %0d",
                     $time, "byte", rsp_out_byte, "kind", rsp_kind,
                     "status", rsp_status, "last", rsp_last);
         end else begin
            want = expected_words.pop_front();
            if (rsp_out_byte !== want.out_byte || rsp_kind !== want.kind ||
                rsp_status !== want.status || rsp_last !== want.last) begin
               error_count++;
               $display("%0t: rsp mismatch, expected %h/%0d/%0d/%0d, actual %h/%0d/%0d/%0d",
                        $time, want.out_byte, want.kind, want.status, want.last,
                        rsp_out_byte, rsp_kind, rsp_status, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      logic [4:0] cfg_val;
      int         phase_end;
      clear_frame();
      min_len = slfd_pkg::MIN_LEN_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED[i])
         send_word(DIRECTED[i].rx, DIRECTED[i].restart, DIRECTED[i].typed, DIRECTED[i].st);
      for (int p = 0; p < 5; p++) begin
         drain_results();
         case (p)
            0:       cfg_val = 5'd0;
            1:       cfg_val = 5'd31;
            2:       cfg_val = 5'($urandom_range(0, 31));
            3:       cfg_val = 5'd1;
            default: cfg_val = slfd_pkg::MIN_LEN_RESET;
         endcase
         csr_valid <= 1'b1;
         csr_data  <= cfg_val;
         do @(posedge clock); while (!csr_ready);
         csr_valid <= 1'b0;
         min_len = cfg_val;
         phase_end = words_taken + 135;
         while (words_taken < phase_end) send_frame();
      end
      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
